// ----- hdl/rsamx_pkg.sv -----
// Shared types, constants and codes for the RSA modular exponentiation engine.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package rsamx_pkg;

    // Word widths of the modulus path and of the prime factors.
    localparam int WORD_W = 32;
    localparam int HALF_W = 16;
    localparam int STEP_W = $clog2(WORD_W);
    localparam logic [HALF_W-1:0] E_VALUE = 16'd3;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_MODULUS_N   = 3'd0,
        REG_PUBLIC_EXP  = 3'd1,
        REG_PRIVATE_EXP = 3'd2,
        REG_PRIME_P     = 3'd3,
        REG_PRIME_Q     = 3'd4
    } cfg_idx_t;

    // Input and result words.
    typedef struct packed {
        logic              mode;
        logic [WORD_W-1:0] data_value;
    } req_t;

    typedef struct packed {
        logic [WORD_W-1:0] result_value;
        logic              error_flag;
    } rsp_t;

    // Register file contents.
    typedef struct packed {
        logic [WORD_W-1:0] modulus_n;
        logic [HALF_W-1:0] public_exp;
        logic [WORD_W-1:0] private_exp;
        logic [HALF_W-1:0] prime_p;
        logic [HALF_W-1:0] prime_q;
    } cfg_t;

    // Operations of the shared arithmetic unit.
    typedef enum logic {
        OP_DIVMOD = 1'b0,
        OP_MULMOD = 1'b1
    } arith_op_t;

    typedef struct packed {
        logic              start;
        arith_op_t         op;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] m;
    } arith_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] rem;
        logic [WORD_W-1:0] quot;
    } arith_rsp_t;

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_WAIT,
        ST_OUT,
        ST_INV_START,
        ST_EU_INIT,
        ST_EU_TEST,
        ST_EU_QT,
        ST_EU_UPD,
        ST_DP_GO,
        ST_DP_SET,
        ST_DQ_GO,
        ST_DQ_SET,
        ST_PW_START,
        ST_PW_BASE,
        ST_PW_TEST,
        ST_PW_ACC,
        ST_PW_SQR,
        ST_PW_END,
        ST_RED_GO,
        ST_DIFF,
        ST_COMB
    } seq_state_t;

    // Which power is being worked out.
    typedef enum logic [1:0] {
        PH_ENC,
        PH_M1,
        PH_M2
    } phase_t;

endpackage

`default_nettype wire

// ----- hdl/rsamx_cfg_regs.sv -----
// Configuration register file of the RSA engine.
// Depends on rsamx_pkg for the register indexes and the cfg_t struct.
`default_nettype none

module rsamx_cfg_regs (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [2:0]                  cfg_index,
    input  wire logic [rsamx_pkg::WORD_W-1:0] cfg_data,
    output rsamx_pkg::cfg_t                  cfg
);
    import rsamx_pkg::*;

    cfg_t cfg_reg;

    // Writes are always taken.
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Register writes; an index beyond the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.modulus_n   <= '0;
            cfg_reg.public_exp  <= E_VALUE;
            cfg_reg.private_exp <= '0;
            cfg_reg.prime_p     <= '0;
            cfg_reg.prime_q     <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MODULUS_N:   cfg_reg.modulus_n   <= cfg_data;
                REG_PUBLIC_EXP:  cfg_reg.public_exp  <= cfg_data[HALF_W-1:0];
                REG_PRIVATE_EXP: cfg_reg.private_exp <= cfg_data;
                REG_PRIME_P:     cfg_reg.prime_p     <= cfg_data[HALF_W-1:0];
                REG_PRIME_Q:     cfg_reg.prime_q     <= cfg_data[HALF_W-1:0];
                default:         ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- hdl/rsamx_arith.sv -----
// Shared bit-serial arithmetic unit: restoring division with remainder and
// interleaved modular multiplication, one bit of the first operand per cycle.
// Depends on rsamx_pkg for the request and response structs.
`default_nettype none

module rsamx_arith (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire rsamx_pkg::arith_req_t req,
    output rsamx_pkg::arith_rsp_t      rsp
);
    import rsamx_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] cnt_reg;
    arith_op_t         op_reg;
    logic [WORD_W-1:0] acc_reg;
    logic [WORD_W-1:0] a_reg;
    logic [WORD_W-1:0] b_reg;
    logic [WORD_W-1:0] m_reg;

    logic [WORD_W-1:0] acc_next;
    logic [WORD_W-1:0] a_next;
    logic [WORD_W:0]   div_r;
    logic [WORD_W:0]   div_s;
    logic              div_ge;
    logic [WORD_W:0]   mul_d;
    logic [WORD_W:0]   mul_e;
    logic [WORD_W:0]   mul_s;
    logic [WORD_W:0]   mul_t;
    logic [WORD_W:0]   m_ext;

    // One step of either operation; the remainder stays below m for b < m, m > 0.
    always_comb
    begin
        m_ext  = {1'b0, m_reg};
        div_r  = {acc_reg, a_reg[WORD_W-1]};
        div_ge = (div_r >= m_ext);
        div_s  = div_ge ? (div_r - m_ext) : div_r;
        mul_d  = {acc_reg, 1'b0};
        mul_e  = (mul_d >= m_ext) ? (mul_d - m_ext) : mul_d;
        mul_s  = a_reg[WORD_W-1] ? (mul_e + {1'b0, b_reg}) : mul_e;
        mul_t  = (mul_s >= m_ext) ? (mul_s - m_ext) : mul_s;
        case (op_reg)
            OP_DIVMOD:
            begin
                acc_next = div_s[WORD_W-1:0];
                a_next   = {a_reg[WORD_W-2:0], div_ge};
            end
            default:
            begin
                acc_next = mul_t[WORD_W-1:0];
                a_next   = {a_reg[WORD_W-2:0], 1'b0};
            end
        endcase
    end

    // Step control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(WORD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operand and partial result registers.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            op_reg  <= req.op;
            acc_reg <= '0;
            a_reg   <= req.a;
            b_reg   <= req.b;
            m_reg   <= req.m;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            a_reg   <= a_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = acc_reg;
    assign rsp.quot = a_reg;

`ifndef SYNTHESIS
    // A new operation is never started while one is under way.
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("arith unit started while busy");

    // The finished remainder or product is reduced below the modulus.
    a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (acc_reg < m_reg))
        else $error("arith result not reduced");

    // Completion comes exactly after the last step.
    a_done_end: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !req.start && cnt_reg == STEP_W'(WORD_W - 1)) |=> (done_reg && !busy_reg))
        else $error("arith completion missed");
`endif

endmodule

`default_nettype wire

// ----- hdl/rsamx_seq.sv -----
// Sequencer of the RSA engine: square-and-multiply, extended Euclid and CRT
// recombination; divisions and modular products go to the shared unit.
// Depends on rsamx_pkg for states, codes and structs.
`default_nettype none

module rsamx_seq (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire rsamx_pkg::cfg_t       cfg,
    input  wire logic                  req_valid,
    output logic                       req_stall,
    input  wire rsamx_pkg::req_t       req,
    output logic                       rsp_valid,
    input  wire logic                  rsp_stall,
    output rsamx_pkg::rsp_t            rsp,
    output rsamx_pkg::arith_req_t      ar,
    input  wire rsamx_pkg::arith_rsp_t ars
);
    import rsamx_pkg::*;

    seq_state_t state_reg, state_next;
    seq_state_t ret_reg, ret_next;

    phase_t            phase_reg, phase_next;
    logic [WORD_W-1:0] data_reg, data_next;
    logic [WORD_W-1:0] base_reg, base_next;
    logic [WORD_W-1:0] acc_reg, acc_next;
    logic [WORD_W-1:0] exp_reg, exp_next;
    logic [WORD_W-1:0] mod_reg, mod_next;
    logic [HALF_W-1:0] r0_reg, r0_next;
    logic [HALF_W-1:0] r1_reg, r1_next;
    logic [HALF_W-1:0] s0_reg, s0_next;
    logic [HALF_W-1:0] s1_reg, s1_next;
    logic [HALF_W-1:0] t_reg, t_next;
    logic [HALF_W-1:0] qinv_reg, qinv_next;
    logic [HALF_W-1:0] m1_reg, m1_next;
    logic [HALF_W-1:0] m2_reg, m2_next;
    logic [WORD_W-1:0] value_reg, value_next;
    logic              err_reg, err_next;

    logic [HALF_W-1:0] p;
    logic [HALF_W-1:0] q;
    logic              req_acc;
    logic              bad_primes;
    logic [HALF_W:0]   s_sum;
    logic [HALF_W:0]   d_sum;
    logic [HALF_W-1:0] diff;
    logic [WORD_W-1:0] hq;

    assign p          = cfg.prime_p;
    assign q          = cfg.prime_q;
    assign req_acc    = req_valid && !req_stall;
    assign bad_primes = (p < HALF_W'(2)) || (q < HALF_W'(2));

    // Small helper arithmetic beside the shared unit.
    always_comb
    begin
        if (s0_reg >= ars.rem[HALF_W-1:0])
            s_sum = {1'b0, s0_reg} - {1'b0, ars.rem[HALF_W-1:0]};
        else
            s_sum = {1'b0, s0_reg} + {1'b0, p} - {1'b0, ars.rem[HALF_W-1:0]};
        d_sum = {1'b0, m1_reg} + {1'b0, p} - {1'b0, ars.rem[HALF_W-1:0]};
        diff  = (d_sum >= {1'b0, p}) ? HALF_W'(d_sum - {1'b0, p}) : d_sum[HALF_W-1:0];
        hq    = {{(WORD_W-HALF_W){1'b0}}, ars.rem[HALF_W-1:0]}
              * {{(WORD_W-HALF_W){1'b0}}, q};
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        unique case (state_reg)
            ST_IDLE:
                if (req_acc)
                begin
                    if (!req.mode)
                        state_next = (cfg.modulus_n == '0) ? ST_OUT : ST_PW_START;
                    else
                        state_next = bad_primes ? ST_OUT : ST_INV_START;
                end
            ST_WAIT:
                if (ars.done)
                    state_next = ret_reg;
            ST_OUT:
                if (!rsp_stall)
                    state_next = ST_IDLE;
            ST_INV_START:
            begin
                state_next = ST_WAIT;
                ret_next   = ST_EU_INIT;
            end
            ST_EU_INIT:
                state_next = ST_EU_TEST;
            ST_EU_TEST:
                if (r1_reg == '0)
                    state_next = (r0_reg == HALF_W'(1)) ? ST_DP_GO : ST_OUT;
                else
                begin
                    state_next = ST_WAIT;
                    ret_next   = ST_EU_QT;
                end
            ST_EU_QT:
            begin
                state_next = ST_WAIT;
                ret_next   = ST_EU_UPD;
            end
            ST_EU_UPD:
                state_next = ST_EU_TEST;
            ST_DP_GO:
            begin
                state_next = ST_WAIT;
                ret_next   = ST_DP_SET;
            end
            ST_DP_SET:
                state_next = ST_PW_START;
            ST_DQ_GO:
            begin
                state_next = ST_WAIT;
                ret_next   = ST_DQ_SET;
            end
            ST_DQ_SET:
                state_next = ST_PW_START;
            ST_PW_START:
                if (exp_reg == '0)
                    state_next = ST_PW_END;
                else
                begin
                    state_next = ST_WAIT;
                    ret_next   = ST_PW_BASE;
                end
            ST_PW_BASE:
                state_next = ST_PW_TEST;
            ST_PW_TEST:
                if (exp_reg == '0)
                    state_next = ST_PW_END;
                else
                begin
                    state_next = ST_WAIT;
                    ret_next   = exp_reg[0] ? ST_PW_ACC : ST_PW_SQR;
                end
            ST_PW_ACC:
            begin
                state_next = ST_WAIT;
                ret_next   = ST_PW_SQR;
            end
            ST_PW_SQR:
                state_next = ST_PW_TEST;
            ST_PW_END:
                case (phase_reg)
                    PH_M1:   state_next = ST_DQ_GO;
                    PH_M2:   state_next = ST_RED_GO;
                    default: state_next = ST_OUT;
                endcase
            ST_RED_GO:
            begin
                state_next = ST_WAIT;
                ret_next   = ST_DIFF;
            end
            ST_DIFF:
            begin
                state_next = ST_WAIT;
                ret_next   = ST_COMB;
            end
            ST_COMB:
                state_next = ST_OUT;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Datapath register updates.
    always_comb
    begin
        phase_next = phase_reg;
        data_next  = data_reg;
        base_next  = base_reg;
        acc_next   = acc_reg;
        exp_next   = exp_reg;
        mod_next   = mod_reg;
        r0_next    = r0_reg;
        r1_next    = r1_reg;
        s0_next    = s0_reg;
        s1_next    = s1_reg;
        t_next     = t_reg;
        qinv_next  = qinv_reg;
        m1_next    = m1_reg;
        m2_next    = m2_reg;
        value_next = value_reg;
        err_next   = err_reg;
        case (state_reg)
            ST_IDLE:
                if (req_acc)
                begin
                    data_next  = req.data_value;
                    value_next = '0;
                    err_next   = 1'b0;
                    if (!req.mode)
                    begin
                        phase_next = PH_ENC;
                        base_next  = req.data_value;
                        exp_next   = {{(WORD_W-HALF_W){1'b0}}, cfg.public_exp};
                        mod_next   = cfg.modulus_n;
                        err_next   = (cfg.modulus_n == '0);
                    end
                    else
                        err_next = bad_primes;
                end
            ST_EU_INIT:
            begin
                r0_next = p;
                r1_next = ars.rem[HALF_W-1:0];
                s0_next = '0;
                s1_next = HALF_W'(1);
            end
            ST_EU_TEST:
                if (r1_reg == '0)
                begin
                    qinv_next = s0_reg;
                    err_next  = (r0_reg != HALF_W'(1));
                end
            ST_EU_QT:
                t_next = ars.rem[HALF_W-1:0];
            ST_EU_UPD:
            begin
                r0_next = r1_reg;
                r1_next = t_reg;
                s0_next = s1_reg;
                s1_next = s_sum[HALF_W-1:0];
            end
            ST_DP_SET:
            begin
                phase_next = PH_M1;
                exp_next   = ars.rem;
                base_next  = data_reg;
                mod_next   = {{(WORD_W-HALF_W){1'b0}}, p};
            end
            ST_DQ_SET:
            begin
                phase_next = PH_M2;
                exp_next   = ars.rem;
                base_next  = data_reg;
                mod_next   = {{(WORD_W-HALF_W){1'b0}}, q};
            end
            ST_PW_START:
                if (exp_reg == '0)
                    acc_next = WORD_W'(1);
            ST_PW_BASE:
            begin
                base_next = ars.rem;
                acc_next  = (mod_reg == WORD_W'(1)) ? '0 : WORD_W'(1);
            end
            ST_PW_ACC:
                acc_next = ars.rem;
            ST_PW_SQR:
            begin
                base_next = ars.rem;
                exp_next  = exp_reg >> 1;
            end
            ST_PW_END:
                case (phase_reg)
                    PH_M1:   m1_next    = acc_reg[HALF_W-1:0];
                    PH_M2:   m2_next    = acc_reg[HALF_W-1:0];
                    default: value_next = acc_reg;
                endcase
            ST_COMB:
                value_next = {{(WORD_W-HALF_W){1'b0}}, m2_reg} + hq;
            default:
                ;
        endcase
    end

    // Outputs: arithmetic requests, handshakes and the result word.
    always_comb
    begin
        ar.start = 1'b0;
        ar.op    = OP_DIVMOD;
        ar.a     = '0;
        ar.b     = '0;
        ar.m     = WORD_W'(1);
        unique case (state_reg)
            ST_INV_START:
            begin
                ar.start = 1'b1;
                ar.a     = {{(WORD_W-HALF_W){1'b0}}, q};
                ar.m     = {{(WORD_W-HALF_W){1'b0}}, p};
            end
            ST_EU_TEST:
            begin
                ar.start = (r1_reg != '0);
                ar.a     = {{(WORD_W-HALF_W){1'b0}}, r0_reg};
                ar.m     = {{(WORD_W-HALF_W){1'b0}}, r1_reg};
            end
            ST_EU_QT:
            begin
                ar.start = 1'b1;
                ar.op    = OP_MULMOD;
                ar.a     = {{(WORD_W-HALF_W){1'b0}}, ars.quot[HALF_W-1:0]};
                ar.b     = {{(WORD_W-HALF_W){1'b0}}, s1_reg};
                ar.m     = {{(WORD_W-HALF_W){1'b0}}, p};
            end
            ST_DP_GO:
            begin
                ar.start = 1'b1;
                ar.a     = cfg.private_exp;
                ar.m     = {{(WORD_W-HALF_W){1'b0}}, HALF_W'(p - 1'b1)};
            end
            ST_DQ_GO:
            begin
                ar.start = 1'b1;
                ar.a     = cfg.private_exp;
                ar.m     = {{(WORD_W-HALF_W){1'b0}}, HALF_W'(q - 1'b1)};
            end
            ST_PW_START:
            begin
                ar.start = (exp_reg != '0);
                ar.a     = base_reg;
                ar.m     = mod_reg;
            end
            ST_PW_TEST:
            begin
                ar.start = (exp_reg != '0);
                ar.op    = OP_MULMOD;
                ar.a     = exp_reg[0] ? acc_reg : base_reg;
                ar.b     = base_reg;
                ar.m     = mod_reg;
            end
            ST_PW_ACC:
            begin
                ar.start = 1'b1;
                ar.op    = OP_MULMOD;
                ar.a     = base_reg;
                ar.b     = base_reg;
                ar.m     = mod_reg;
            end
            ST_RED_GO:
            begin
                ar.start = 1'b1;
                ar.a     = {{(WORD_W-HALF_W){1'b0}}, m2_reg};
                ar.m     = {{(WORD_W-HALF_W){1'b0}}, p};
            end
            ST_DIFF:
            begin
                ar.start = 1'b1;
                ar.op    = OP_MULMOD;
                ar.a     = {{(WORD_W-HALF_W){1'b0}}, qinv_reg};
                ar.b     = {{(WORD_W-HALF_W){1'b0}}, diff};
                ar.m     = {{(WORD_W-HALF_W){1'b0}}, p};
            end
            default:
                ;
        endcase
        req_stall        = (state_reg != ST_IDLE);
        rsp_valid        = (state_reg == ST_OUT);
        rsp.result_value = err_reg ? '0 : value_reg;
        rsp.error_flag   = err_reg;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        phase_reg <= phase_next;
        data_reg  <= data_next;
        base_reg  <= base_next;
        acc_reg   <= acc_next;
        exp_reg   <= exp_next;
        mod_reg   <= mod_next;
        r0_reg    <= r0_next;
        r1_reg    <= r1_next;
        s0_reg    <= s0_next;
        s1_reg    <= s1_next;
        t_reg     <= t_next;
        qinv_reg  <= qinv_next;
        m1_reg    <= m1_next;
        m2_reg    <= m2_next;
        value_reg <= value_next;
        err_reg   <= err_next;
    end

endmodule

`default_nettype wire

// ----- hdl/rsa_modexp_crt_engine_unit.sv -----
// RSA modular exponentiation engine with CRT decryption, 32-bit words.
// Channels: req (mode, data_value) with req_valid/req_stall, rsp
// (result_value, error_flag) with rsp_valid/rsp_stall; a word moves at an
// edge where valid is high and stall is low.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; indexes
// 0 modulus_n, 1 public_exp, 2 private_exp, 3 prime_p, 4 prime_q.
// One word is processed at a time; req_stall is high from acceptance until
// the result word has been taken. The divisions and modular products all run
// on one bit-serial arithmetic unit. Encrypt runs one base reduction, then a
// squaring for each exponent bit and a product for each one bit. Decrypt runs
// the Euclid loop (two operations per quotient step), two reductions of d,
// two powers over up to 16 exponent bits and a final reduction and product.
// Errors (zero modulus, a prime below two, no inverse) finish early with a
// zero result and error_flag set.
// Reset clears the sequencer to idle and the configuration registers to their
// defaults (public_exp = 3). While rsp_stall is high the result word is held.
// Depends on rsamx_pkg, rsamx_cfg_regs, rsamx_arith and rsamx_seq.
`default_nettype none

module rsa_modexp_crt_engine_unit (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         req_valid,
    output logic                              req_stall,
    input  wire rsamx_pkg::req_t              req,
    output logic                              rsp_valid,
    input  wire logic                         rsp_stall,
    output rsamx_pkg::rsp_t                   rsp,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [2:0]                   cfg_index,
    input  wire logic [rsamx_pkg::WORD_W-1:0] cfg_data
);
    import rsamx_pkg::*;

    cfg_t       cfg;
    arith_req_t ar;
    arith_rsp_t ars;

    // Register file.
    rsamx_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Shared arithmetic unit.
    rsamx_arith u_arith (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ar),
        .rsp   (ars)
    );

    // Sequencer.
    rsamx_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .ar        (ar),
        .ars       (ars)
    );

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for rsa_modexp_crt_engine_unit: directed rows, then random words.
// It predicts results not typed in the table and compares each result word field by field.
// Depends on rsamx_pkg and on the engine's RTL.
`default_nettype none

module tb;
    import rsamx_pkg::*;

    localparam int  RANDOM_WORDS = 480;
    localparam int  WORDS_PER_KEY = 40;
    localparam int  LONG_HOLD = 6000;
    localparam longint CYCLE_LIMIT = 12000000;

    // One row of the directed table: key set, request word and an optional typed result.
    typedef struct {
        int          key_set;
        logic        mode;
        logic [31:0] data;
        bit          known;
        logic [31:0] known_value;
        logic        known_error;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    req_t        req;
    logic        rsp_valid;
    logic        rsp_stall;
    rsp_t        rsp;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    // Local copy of the key registers.
    logic [31:0] key_n;
    logic [15:0] key_e;
    logic [31:0] key_d;
    logic [15:0] key_p;
    logic [15:0] key_q;

    rsp_t   pending_results[$];
    int     mismatches;
    longint cycle_count;
    bit     hold_request;
    int     hold_left;

    rsa_modexp_crt_engine_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock with a period of 12.
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // base^ex mod m by square-and-multiply; a zero exponent gives 1 unreduced.
    function automatic longint unsigned power_mod(longint unsigned base, longint unsigned ex,
                                                  longint unsigned m);
        longint unsigned acc;
        if (ex == 0)
            return 1;
        base = base % m;
        acc = 1 % m;
        while (ex != 0)
        begin
            if (ex[0])
                acc = (acc * base) % m;
            base = (base * base) % m;
            ex = ex >> 1;
        end
        return acc;
    endfunction

    // Inverse of a modulo m by extended Euclid; found is cleared when none exists.
    function automatic longint unsigned inverse_mod(longint unsigned a, longint unsigned m,
                                                    output bit found);
        longint r0, r1, s0, s1, qt, t;
        r0 = longint'(m);
        r1 = longint'(a % m);
        s0 = 0;
        s1 = 1;
        while (r1 != 0)
        begin
            qt = r0 / r1;
            t = r0 - qt * r1;
            r0 = r1;
            r1 = t;
            t = s0 - qt * s1;
            s0 = s1;
            s1 = t;
        end
        found = (r0 == 1);
        s0 = s0 % longint'(m);
        if (s0 < 0)
            s0 = s0 + longint'(m);
        return longint'(s0);
    endfunction

    // Result word for one request under the current key registers.
    function automatic rsp_t rsa_result(logic mode, logic [31:0] data);
        rsp_t res;
        longint unsigned p, q, qinv, m1, m2, diff, h, full;
        bit found;
        res.result_value = '0;
        res.error_flag = 1'b0;
        p = key_p;
        q = key_q;
        if (!mode)
        begin
            if (key_n == 0)
                res.error_flag = 1'b1;
            else
                res.result_value = 32'(power_mod(data, key_e, key_n));
        end
        else
        begin
            found = 1'b0;
            if (p >= 2 && q >= 2)
                qinv = inverse_mod(q, p, found);
            if (!found)
                res.error_flag = 1'b1;
            else
            begin
                m1 = power_mod(data, key_d % (p - 1), p);
                m2 = power_mod(data, key_d % (q - 1), q);
                diff = (m1 + p - (m2 % p)) % p;
                h = (qinv * diff) % p;
                full = m2 + h * q;
                res.result_value = full[31:0];
            end
        end
        return res;
    endfunction

    // Register write on the configuration channel; the upper bits carry noise for 16-bit ones.
    task automatic write_reg(cfg_idx_t idx, logic [31:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_MODULUS_N:   key_n = value;
            REG_PUBLIC_EXP:  key_e = value[15:0];
            REG_PRIVATE_EXP: key_d = value;
            REG_PRIME_P:     key_p = value[15:0];
            REG_PRIME_Q:     key_q = value[15:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Wait until every outstanding result word has arrived, then a short settling pause.
    task automatic drain;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic load_keys(logic [31:0] n, logic [15:0] e, logic [31:0] d,
                             logic [15:0] p, logic [15:0] q);
        drain();
        write_reg(REG_MODULUS_N, n);
        write_reg(REG_PUBLIC_EXP, {16'($urandom), e});
        write_reg(REG_PRIVATE_EXP, d);
        write_reg(REG_PRIME_P, {16'($urandom), p});
        write_reg(REG_PRIME_Q, {16'($urandom), q});
    endtask

    // Gap length: mostly none or short, now and then long.
    function automatic int idle_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            return 0;
        if (pick < 92)
            return $urandom_range(1, 4);
        return $urandom_range(20, 80);
    endfunction

    // Offer one request word and record its expected result once it is taken.
    task automatic send_word(logic mode, logic [31:0] data, bit known,
                             logic [31:0] known_value, logic known_error);
        int gap;
        rsp_t res;
        @(negedge clk);
        gap = idle_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req.mode <= mode;
        req.data_value <= data;
        do
            @(posedge clk);
        while (req_stall);
        if (known)
        begin
            res.result_value = known_value;
            res.error_flag = known_error;
        end
        else
            res = rsa_result(mode, data);
        pending_results.push_back(res);
    endtask

    task automatic go_idle;
        @(negedge clk);
        req_valid <= 1'b0;
    endtask

    // Result stall: random, with stall-free stretches and one long hold on request.
    always @(negedge clk)
    begin
        if (hold_request && hold_left == 0)
        begin
            hold_left <= LONG_HOLD;
            hold_request <= 1'b0;
            rsp_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
        end
        else if (cycle_count % 4000 < 1500)
            rsp_stall <= 1'b0;
        else if ($urandom_range(0, 99) < 3)
        begin
            hold_left <= $urandom_range(20, 80);
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= ($urandom_range(0, 99) < 35);
    end

    // Result checker: each taken word against the oldest expectation.
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result word with no expectation: value %0h error %0b",
                       rsp.result_value, rsp.error_flag);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp.result_value !== want.result_value)
                begin
                    $error("result_value: expected %0h, actual %0h",
                           want.result_value, rsp.result_value);
                    mismatches++;
                end
                if (rsp.error_flag !== want.error_flag)
                begin
                    $error("error_flag: expected %0b, actual %0b",
                           want.error_flag, rsp.error_flag);
                    mismatches++;
                end
            end
        end
    end

    // Cycle counter and run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Directed key sets: defaults, textbook key, tiny moduli, extremes and awkward primes.
    task automatic apply_key_set(int set);
        case (set)
            1: load_keys(32'd3233, 16'd17, 32'd2753, 16'd61, 16'd53);
            2: load_keys(32'd1, 16'd0, 32'd0, 16'd3, 16'd3);
            3: load_keys(32'd1, 16'd5, 32'd7, 16'd1, 16'd7);
            4: load_keys(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'd65521, 16'd65519);
            5: load_keys(32'd98, 16'd1, 32'd9, 16'd7, 16'd14);
            6: load_keys(32'd485, 16'd2, 32'd0, 16'd5, 16'd97);
            7: load_keys(32'd6, 16'd7, 32'd11, 16'd2, 16'd3);
            default: ;
        endcase
    endtask

    initial
    begin
        dir_row_t rows[$];
        int cur_set;
        int sent;
        logic [15:0] p, q;
        logic [31:0] n;

        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        rsp_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mismatches = 0;
        cycle_count = 0;
        hold_request = 1'b0;
        hold_left = 0;
        key_n = '0;
        key_e = E_VALUE;
        key_d = '0;
        key_p = '0;
        key_q = '0;

        rows = '{
            '{0, 1'b0, 32'd0,          1'b1, 32'd0,    1'b1},
            '{0, 1'b0, 32'hFFFF_FFFF,  1'b1, 32'd0,    1'b1},
            '{0, 1'b1, 32'd5,          1'b1, 32'd0,    1'b1},
            '{1, 1'b0, 32'd65,         1'b1, 32'd2790, 1'b0},
            '{1, 1'b1, 32'd2790,       1'b1, 32'd65,   1'b0},
            '{1, 1'b0, 32'd0,          1'b0, 32'd0,    1'b0},
            '{1, 1'b0, 32'hFFFF_FFFF,  1'b0, 32'd0,    1'b0},
            '{1, 1'b1, 32'd0,          1'b0, 32'd0,    1'b0},
            '{1, 1'b1, 32'hFFFF_FFFF,  1'b0, 32'd0,    1'b0},
            '{2, 1'b0, 32'd123,        1'b1, 32'd1,    1'b0},
            '{2, 1'b1, 32'd10,         1'b1, 32'd0,    1'b1},
            '{3, 1'b0, 32'd7,          1'b1, 32'd0,    1'b0},
            '{3, 1'b1, 32'd7,          1'b1, 32'd0,    1'b1},
            '{4, 1'b0, 32'hFFFF_FFFF,  1'b0, 32'd0,    1'b0},
            '{4, 1'b0, 32'd2,          1'b0, 32'd0,    1'b0},
            '{4, 1'b1, 32'hFFFF_FFFF,  1'b0, 32'd0,    1'b0},
            '{4, 1'b1, 32'd12345,      1'b0, 32'd0,    1'b0},
            '{5, 1'b1, 32'd3,          1'b1, 32'd0,    1'b1},
            '{5, 1'b0, 32'd200,        1'b0, 32'd0,    1'b0},
            '{6, 1'b1, 32'd4242,       1'b0, 32'd0,    1'b0},
            '{6, 1'b0, 32'h8000_0000,  1'b0, 32'd0,    1'b0},
            '{7, 1'b1, 32'd5,          1'b0, 32'd0,    1'b0},
            '{7, 1'b1, 32'hDEAD_BEEF,  1'b0, 32'd0,    1'b0}
        };

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (4) @(negedge clk);

        // Directed part: each change of key set waits for the engine to go idle.
        cur_set = 0;
        foreach (rows[i])
        begin
            if (rows[i].key_set != cur_set)
            begin
                go_idle();
                cur_set = rows[i].key_set;
                apply_key_set(cur_set);
            end
            send_word(rows[i].mode, rows[i].data, rows[i].known,
                      rows[i].known_value, rows[i].known_error);
        end
        go_idle();

        // Random part: fresh keys every few dozen words; one batch runs under a long hold.
        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                p = 16'($urandom_range(0, 65535));
                q = 16'($urandom_range(0, 65535));
            end
            else
            begin
                p = 16'($urandom_range(0, 300));
                q = 16'($urandom_range(0, 300));
            end
            if ($urandom_range(0, 9) < 7)
                n = 32'(p) * 32'(q);
            else
                n = $urandom;
            load_keys(n, 16'($urandom), $urandom, p, q);
            if (sent == 2 * WORDS_PER_KEY)
                hold_request = 1'b1;
            repeat (WORDS_PER_KEY)
            begin
                send_word(1'($urandom), $urandom, 1'b0, 32'd0, 1'b0);
                sent++;
            end
            go_idle();
        end

        // Wind-down: all results in, then a quiet spell.
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
hdl/rsamx_pkg.sv
hdl/rsamx_cfg_regs.sv
hdl/rsamx_arith.sv
hdl/rsamx_seq.sv
hdl/rsa_modexp_crt_engine_unit.sv
tb/tb.sv
